### design/cts_pkg.sv
// Shared types, command codes and display tables for the clock/temperature digit scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cts_pkg;

   localparam int unsigned DEFAULT_DAY_SECONDS = 43200;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam int unsigned TIME_FRAMES = 6;
   localparam int unsigned TEMP_FRAMES = 4;

   // request op codes
   localparam logic [3:0] OP_TICK      = 4'd0;
   localparam logic [3:0] OP_SHOW_TEMP = 4'd1;
   localparam logic [3:0] OP_SHOW_TIME = 4'd2;
   localparam logic [3:0] OP_MIN_UP    = 4'd3;
   localparam logic [3:0] OP_MIN_DOWN  = 4'd4;
   localparam logic [3:0] OP_HOUR_UP   = 4'd5;
   localparam logic [3:0] OP_HOUR_DOWN = 4'd6;
   localparam logic [3:0] OP_SAMPLE    = 4'd7;
   localparam logic [3:0] OP_REFRESH   = 4'd8;

   localparam logic [7:0] POINT_BIT = 8'h80;

   typedef enum logic [3:0] {
      CMD_TICK,
      CMD_SHOW_TEMP,
      CMD_SHOW_TIME,
      CMD_MIN_UP,
      CMD_MIN_DOWN,
      CMD_HOUR_UP,
      CMD_HOUR_DOWN,
      CMD_SAMPLE,
      CMD_REFRESH
   } cmd_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [10:0] temp_raw;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       last;
   } rsp_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [10:0] temp_raw;
   } cmd_entry_type;

   // common-cathode glyphs, bits 0..6 = a..g
   localparam logic [7:0] SEG_GLYPH [16] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
   };

   // time frame order: sec tens, sec units, min tens, min units, hour tens, hour units
   localparam logic [2:0] TIME_POS [TIME_FRAMES] = '{3'd6, 3'd7, 3'd3, 3'd4, 3'd0, 3'd1};
   localparam logic       TIME_POINT [TIME_FRAMES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

   // temperature frame order: thousands, hundreds (point), tens, units of hundredths
   localparam logic [2:0]  TEMP_POS [TEMP_FRAMES] = '{3'd2, 3'd3, 3'd4, 3'd5};
   localparam logic        TEMP_POINT [TEMP_FRAMES] = '{1'b0, 1'b1, 1'b0, 1'b0};
   localparam logic [13:0] TEMP_PLACE [TEMP_FRAMES] = '{14'd1000, 14'd100, 14'd10, 14'd1};

endpackage

### design/cts_front.sv
// Front end of the scanner: accepts request transactions and classifies op codes.
// Depends on cts_pkg; feeds cts_queue.
`timescale 1ns / 1ps

module cts_front
   import cts_pkg::*;
(
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_stall,
   input  logic          q_full,
   output logic          push,
   output cmd_entry_type push_entry
);

   logic    known;
   cmd_type cmd;

   always_comb begin
      known = 1'b1;
      cmd   = CMD_TICK;
      unique case (req_data.op)
         OP_TICK:      cmd = CMD_TICK;
         OP_SHOW_TEMP: cmd = CMD_SHOW_TEMP;
         OP_SHOW_TIME: cmd = CMD_SHOW_TIME;
         OP_MIN_UP:    cmd = CMD_MIN_UP;
         OP_MIN_DOWN:  cmd = CMD_MIN_DOWN;
         OP_HOUR_UP:   cmd = CMD_HOUR_UP;
         OP_HOUR_DOWN: cmd = CMD_HOUR_DOWN;
         OP_SAMPLE:    cmd = CMD_SAMPLE;
         OP_REFRESH:   cmd = CMD_REFRESH;
         default:      known = 1'b0;
      endcase
   end

   assign req_stall           = q_full;
   // unused op codes are accepted and dropped here
   assign push                = req_valid && !q_full && known;
   assign push_entry.cmd      = cmd;
   assign push_entry.temp_raw = req_data.temp_raw;

endmodule

### design/cts_queue.sv
// Short command queue between the classifier and the execution back end.
// Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_queue
   import cts_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   output logic          full,
   output logic          q_valid,
   output cmd_entry_type q_entry,
   input  logic          pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = entry_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !pop)
      else $error("pop from empty queue");

endmodule

### design/cts_back.sv
// Back end of the scanner: executes clock/mode/sample commands and scans refresh
// frames out through a registered result stage. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_back
   import cts_pkg::*;
#(
   parameter int unsigned DAY_SECONDS = DEFAULT_DAY_SECONDS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int unsigned CNT_W = $clog2(DAY_SECONDS);

   localparam logic [CNT_W-1:0] LIMIT_TICK = CNT_W'(DAY_SECONDS - 1);
   localparam logic [CNT_W-1:0] LIMIT_MIN  = CNT_W'(DAY_SECONDS - 60);
   localparam logic [CNT_W-1:0] LIMIT_HOUR = CNT_W'(DAY_SECONDS - 3600);

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } digit_pair_type;

   function automatic digit_pair_type split_tens(input logic [5:0] v);
      digit_pair_type r;
      r.tens  = '0;
      r.units = v[3:0];
      for (int k = 1; k <= 5; k++) begin
         if (v >= 6'(k * 10)) begin
            r.tens  = 4'(k);
            r.units = 4'(v - 6'(k * 10));
         end
      end
      return r;
   endfunction

   // clock and display state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [5:0]       sec_ff, sec_in;
   logic [5:0]       min_ff, min_in;
   logic [4:0]       hour_ff, hour_in;
   logic             show_time_ff, show_time_in;
   logic [10:0]      held_temp_ff, held_temp_in;

   // frame scanner
   logic             emit_busy_ff, emit_busy_in;
   logic             emit_time_ff, emit_time_in;
   logic [2:0]       emit_step_ff, emit_step_in;
   logic [13:0]      emit_rem_ff, emit_rem_in;
   logic [5:0]       snap_sec_ff, snap_sec_in;
   logic [5:0]       snap_min_ff, snap_min_in;
   logic [4:0]       snap_hour_ff, snap_hour_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             advance, fire, final_step, load_ok, is_refresh, load, exec;
   logic [15:0]      temp_x25;
   logic [13:0]      hund;
   logic [13:0]      place, sub;
   logic [3:0]       temp_digit;
   digit_pair_type   sec_pair, min_pair, hour_pair;
   logic [2:0]       pos;
   logic [3:0]       digit;
   logic             point;
   rsp_type          frame;

   // hundredths of a degree: raw * 25 / 4
   assign temp_x25 = {1'b0, held_temp_ff, 4'b0} + {2'b0, held_temp_ff, 3'b0}
                   + {5'b0, held_temp_ff};
   assign hund     = temp_x25[15:2];

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = emit_busy_ff && advance;
   assign final_step = emit_time_ff ? (emit_step_ff == 3'(TIME_FRAMES - 1))
                                    : (emit_step_ff == 3'(TEMP_FRAMES - 1));
   assign load_ok    = !emit_busy_ff || (fire && final_step);
   assign is_refresh = (q_entry.cmd == CMD_REFRESH);
   assign q_pop      = q_valid && (!is_refresh || load_ok);
   assign load       = q_pop && is_refresh;
   assign exec       = q_pop && !is_refresh;

   // command execution; a count leaving the day clears all fields
   always_comb begin
      count_in     = count_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      show_time_in = show_time_ff;
      held_temp_in = held_temp_ff;
      if (exec) begin
         unique case (q_entry.cmd)
            CMD_TICK: begin
               if (count_ff >= LIMIT_TICK) begin
                  count_in = '0; sec_in = '0; min_in = '0; hour_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (sec_ff == 6'd59) begin
                     sec_in = '0;
                     if (min_ff == 6'd59) begin
                        min_in  = '0;
                        hour_in = hour_ff + 1'b1;
                     end else begin
                        min_in = min_ff + 1'b1;
                     end
                  end else begin
                     sec_in = sec_ff + 1'b1;
                  end
               end
            end
            CMD_MIN_UP: begin
               if (count_ff >= LIMIT_MIN) begin
                  count_in = '0; sec_in = '0; min_in = '0; hour_in = '0;
               end else begin
                  count_in = count_ff + CNT_W'(60);
                  if (min_ff == 6'd59) begin
                     min_in  = '0;
                     hour_in = hour_ff + 1'b1;
                  end else begin
                     min_in = min_ff + 1'b1;
                  end
               end
            end
            CMD_MIN_DOWN: begin
               if (count_ff < CNT_W'(60)) begin
                  count_in = '0; sec_in = '0; min_in = '0; hour_in = '0;
               end else begin
                  count_in = count_ff - CNT_W'(60);
                  if (min_ff == '0) begin
                     min_in  = 6'd59;
                     hour_in = hour_ff - 1'b1;
                  end else begin
                     min_in = min_ff - 1'b1;
                  end
               end
            end
            CMD_HOUR_UP: begin
               if (count_ff >= LIMIT_HOUR) begin
                  count_in = '0; sec_in = '0; min_in = '0; hour_in = '0;
               end else begin
                  count_in = count_ff + CNT_W'(3600);
                  hour_in  = hour_ff + 1'b1;
               end
            end
            CMD_HOUR_DOWN: begin
               if (count_ff < CNT_W'(3600)) begin
                  count_in = '0; sec_in = '0; min_in = '0; hour_in = '0;
               end else begin
                  count_in = count_ff - CNT_W'(3600);
                  hour_in  = hour_ff - 1'b1;
               end
            end
            CMD_SHOW_TEMP: show_time_in = 1'b0;
            CMD_SHOW_TIME: show_time_in = 1'b1;
            CMD_SAMPLE:    held_temp_in = q_entry.temp_raw;
            default: ;
         endcase
      end
   end

   // one decimal digit of the temperature per frame, most significant first
   always_comb begin
      place      = TEMP_PLACE[emit_step_ff[1:0]];
      temp_digit = '0;
      sub        = '0;
      for (int k = 1; k <= 12; k++) begin
         if (emit_rem_ff >= 14'(k) * place) begin
            temp_digit = 4'(k);
            sub        = 14'(k) * place;
         end
      end
   end

   assign sec_pair  = split_tens(snap_sec_ff);
   assign min_pair  = split_tens(snap_min_ff);
   assign hour_pair = split_tens({1'b0, snap_hour_ff});

   always_comb begin
      pos   = '0;
      digit = '0;
      point = 1'b0;
      if (emit_time_ff) begin
         pos   = TIME_POS[emit_step_ff];
         point = TIME_POINT[emit_step_ff];
         case (emit_step_ff)
            3'd0:    digit = sec_pair.tens;
            3'd1:    digit = sec_pair.units;
            3'd2:    digit = min_pair.tens;
            3'd3:    digit = min_pair.units;
            3'd4:    digit = hour_pair.tens;
            default: digit = hour_pair.units;
         endcase
      end else begin
         pos   = TEMP_POS[emit_step_ff[1:0]];
         point = TEMP_POINT[emit_step_ff[1:0]];
         digit = temp_digit;
      end
      frame.digit_select = ~(8'd1 << pos);
      frame.segments     = SEG_GLYPH[digit] | (point ? POINT_BIT : 8'h00);
      frame.last         = final_step;
   end

   always_comb begin
      emit_busy_in = emit_busy_ff;
      emit_time_in = emit_time_ff;
      emit_step_in = emit_step_ff;
      emit_rem_in  = emit_rem_ff;
      snap_sec_in  = snap_sec_ff;
      snap_min_in  = snap_min_ff;
      snap_hour_in = snap_hour_ff;
      if (fire) begin
         emit_step_in = emit_step_ff + 1'b1;
         emit_rem_in  = emit_rem_ff - sub;
         if (final_step) begin
            emit_busy_in = 1'b0;
         end
      end
      // the refresh takes a snapshot, so later commands may run during the scan
      if (load) begin
         emit_busy_in = 1'b1;
         emit_time_in = show_time_ff;
         emit_step_in = '0;
         emit_rem_in  = hund;
         snap_sec_in  = sec_ff;
         snap_min_in  = min_ff;
         snap_hour_in = hour_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = fire;
         if (fire) begin
            rsp_data_in = frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         hour_ff      <= '0;
         show_time_ff <= 1'b0;
         held_temp_ff <= '0;
         emit_busy_ff <= 1'b0;
         emit_time_ff <= 1'b0;
         emit_step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         show_time_ff <= show_time_in;
         held_temp_ff <= held_temp_in;
         emit_busy_ff <= emit_busy_in;
         emit_time_ff <= emit_time_in;
         emit_step_ff <= emit_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      emit_rem_ff  <= emit_rem_in;
      snap_sec_ff  <= snap_sec_in;
      snap_min_ff  <= snap_min_in;
      snap_hour_ff <= snap_hour_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_in_day: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < DAY_SECONDS)
      else $error("second count outside the day");

   a_fields_match_count: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == 32'(hour_ff) * 3600 + 32'(min_ff) * 60 + 32'(sec_ff))
      else $error("hour/minute/second fields disagree with count");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      emit_busy_ff |-> (emit_time_ff ? (emit_step_ff <= 3'(TIME_FRAMES - 1))
                                     : (emit_step_ff <= 3'(TEMP_FRAMES - 1))))
      else $error("frame step past end of refresh");

endmodule

### design/clock_temperature_digit_scanner.sv
// Top level of the twelve-hour clock / temperature display scanner.
// Depends on cts_pkg, cts_front, cts_queue and cts_back.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one event per transaction:
//   tick, mode select, minute/hour up/down, temperature sample or refresh.
//   Unused op codes are accepted and ignored.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) carries display frames: an active-low
//   digit select, a segment byte (bit 7 decimal point) and a last flag.
//   A refresh yields six frames in time mode and four in temperature mode.
// Timing:
//   Accepted events go into a small command queue; req_stall is high only while it
//   is full. A taken refresh passes through the queue entry, the frame scanner and
//   the output register, and frames follow one per cycle while rsp_stall is low;
//   other events are executed straight from the queue and can run while a refresh
//   is being scanned out.
//   A stalled frame holds in the output register; the queue keeps taking events
//   until it fills.
// Reset: synchronous; clears the count to 00:00:00, selects temperature mode,
//   clears the held sample and empties the queue and the output register.
`timescale 1ns / 1ps

module clock_temperature_digit_scanner
   import cts_pkg::*;
#(
   parameter int unsigned DAY_SECONDS = DEFAULT_DAY_SECONDS,
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic          q_full, push, q_valid, q_pop;
   cmd_entry_type push_entry, q_entry;

   cts_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (q_pop)
   );

   cts_back #(
      .DAY_SECONDS (DAY_SECONDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
